// File: design/smd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package smd_pkg;

  typedef struct packed {
    logic        fin;
    logic [31:0] word;
  } smd_word_t;

  typedef enum logic {FR_ACC, FR_PAD} front_state_e;
  typedef enum logic [1:0] {BK_LOAD, BK_ROUND, BK_ADD, BK_OUT} back_state_e;

  localparam int unsigned FifoDepth = 4;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenOffset = 6'd56;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/smd_front.sv
`timescale 1ns / 1ps
`default_nettype none
module smd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  output logic                  full_o,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             is_last_i,
  input  wire logic             no_byte_i,
  output logic                  wr_valid_o,
  output smd_pkg::smd_word_t    wr_data_o,
  input  wire logic             wr_ready_i
);
  import smd_pkg::*;

  front_state_e state_q, state_d;
  logic [5:0]  fill_q, fill_d, fill_f;
  logic [63:0] bits_q, bits_d;
  logic [31:0] word_q, word_d, pad_q, pad_d, placed, merged, src;
  logic [3:0]  idx_q, idx_d;
  logic        extra_q, extra_d, first_q, first_d;
  logic        take, has, len_fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_ACC;
      fill_q  <= '0;
      bits_q  <= '0;
      idx_q   <= '0;
      extra_q <= 1'b0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      idx_q   <= idx_d;
      extra_q <= extra_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    pad_q  <= pad_d;
  end

  always_comb begin
    full_o  = (state_q != FR_ACC) || !wr_ready_i;
    take    = push_i && !full_o;
    has     = take && !no_byte_i;
    placed  = {data_byte_i, 24'b0} >> {fill_q[1:0], 3'b000};
    merged  = (fill_q[1:0] == 2'd0) ? placed : (word_q | placed);
    len_fin = (idx_q == 4'd15) && !extra_q;
    state_d = state_q;
    fill_d  = fill_q;
    bits_d  = bits_q;
    word_d  = word_q;
    pad_d   = pad_q;
    idx_d   = idx_q;
    extra_d = extra_q;
    first_d = first_q;
    fill_f  = fill_q;
    src     = word_q;
    wr_valid_o = 1'b0;
    wr_data_o  = '{fin: 1'b0, word: merged};
    case (state_q)
      FR_ACC: begin
        if (has) begin
          word_d = merged;
          fill_d = fill_q + 6'd1;
          bits_d = bits_q + 64'd8;
          fill_f = fill_d;
          src    = merged;
          wr_valid_o = (fill_q[1:0] == 2'd3);
        end
        if (take && is_last_i) begin
          state_d = FR_PAD;
          pad_d = (fill_f[1:0] == 2'd0) ? {PadByte, 24'b0} :
                  (src | ({PadByte, 24'b0} >> {fill_f[1:0], 3'b000}));
          idx_d   = fill_f[5:2];
          extra_d = (fill_f >= LenOffset);
          first_d = 1'b1;
        end
      end
      FR_PAD: begin
        wr_valid_o = 1'b1;
        wr_data_o.fin = len_fin;
        if (first_q) begin
          wr_data_o.word = pad_q;
        end else if (idx_q == 4'd14 && !extra_q) begin
          wr_data_o.word = bits_q[63:32];
        end else if (len_fin) begin
          wr_data_o.word = bits_q[31:0];
        end else begin
          wr_data_o.word = '0;
        end
        if (wr_ready_i) begin
          idx_d   = idx_q + 4'd1;
          first_d = 1'b0;
          if (idx_q == 4'd15) begin
            extra_d = 1'b0;
          end
          if (len_fin) begin
            state_d = FR_ACC;
            fill_d  = '0;
            bits_d  = '0;
          end
        end
      end
      default: state_d = FR_ACC;
    endcase
  end
endmodule
`default_nettype wire

// File: design/smd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module smd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  input  smd_pkg::smd_word_t    wr_data_i,
  output logic                  wr_ready_o,
  output logic                  rd_valid_o,
  output smd_pkg::smd_word_t    rd_data_o,
  input  wire logic             rd_ready_i
);
  import smd_pkg::*;

  localparam int unsigned AW = $clog2(FifoDepth);

  smd_word_t          mem_q [FifoDepth];
  logic [AW-1:0]      wp_q, rp_q;
  logic [AW:0]        cnt_q;
  logic               wr, rd;

  assign wr_ready_o = (cnt_q != (AW+1)'(FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_ready_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + AW'(1);
      if (rd) rp_q <= rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
`default_nettype wire

// File: design/smd_back.sv
`timescale 1ns / 1ps
`default_nettype none
module smd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             rd_valid_i,
  input  smd_pkg::smd_word_t    rd_data_i,
  output logic                  rd_ready_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output logic [31:0]           digest_word_o,
  output logic [2:0]            word_index_o,
  output logic                  last_word_o
);
  import smd_pkg::*;

  back_state_e state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  cnt_q, cnt_d;
  logic        fin_q, ov_q, ov_d, oload;
  logic [31:0] s0, s1, w_new, bs0, bs1, ch, maj, t1, t2;

  assign empty_o = !ov_q;
  assign rd_ready_o = (state_q == BK_LOAD);

  always_comb begin
    s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
         ^ (w_q[14] >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    bs1 = {v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
          ^ {v_q[4][24:0], v_q[4][31:25]};
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + bs1 + ch + round_k(cnt_q) + w_q[0];
    bs0 = {v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
          ^ {v_q[0][21:0], v_q[0][31:22]};
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = bs0 + maj;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    oload   = 1'b0;
    ov_d    = ov_q && !pop_i;
    case (state_q)
      BK_LOAD: begin
        if (rd_valid_i) begin
          cnt_d = cnt_q + 6'd1;
          if (cnt_q == 6'd15) begin
            state_d = BK_ROUND;
            cnt_d   = '0;
          end
        end
      end
      BK_ROUND: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) state_d = BK_ADD;
      end
      BK_ADD: begin
        cnt_d   = '0;
        state_d = fin_q ? BK_OUT : BK_LOAD;
      end
      BK_OUT: begin
        if (!ov_q || pop_i) begin
          oload = 1'b1;
          ov_d  = 1'b1;
          cnt_d = cnt_q + 6'd1;
          if (cnt_q[2:0] == 3'd7) begin
            state_d = BK_LOAD;
            cnt_d   = '0;
          end
        end
      end
      default: state_d = BK_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_LOAD;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
      fin_q   <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
      if (state_q == BK_LOAD && rd_valid_i && cnt_q == 6'd15) fin_q <= rd_data_i.fin;
      if (state_q == BK_ADD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      // restart from the initial hash once the last digest word leaves
      if (oload && cnt_q[2:0] == 3'd7) begin
        for (int i = 0; i < 8; i++) h_q[i] <= iv_word(3'(i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_LOAD && rd_valid_i) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= rd_data_i.word;
      if (cnt_q == 6'd15) begin
        for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
      end
    end
    if (state_q == BK_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (oload) begin
      digest_word_o <= h_q[cnt_q[2:0]];
      word_index_o  <= cnt_q[2:0];
      last_word_o   <= (cnt_q[2:0] == 3'd7);
    end
  end
endmodule
`default_nettype wire

// File: design/sha256_message_digest_top.sv
// Each 64-byte block takes 16 word loads, 64 rounds and 1 hash add, run by the single-round
// compression unit; the final item adds one or two padded blocks.
// The 4-word queue fills during the round and add steps, then the front refills the other
// 12 words at one byte per cycle while the queue has room.
// Output: eight digest words, one per cycle while pop keeps up.
// Reset: asynchronous active low; clears control and loads the initial hash value.
`timescale 1ns / 1ps
`default_nettype none
module sha256_message_digest_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        is_last_i,
  input  wire logic        no_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import smd_pkg::*;

  smd_word_t wr_data, rd_data;
  logic      wr_valid, wr_ready, rd_valid, rd_ready;

  smd_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .data_byte_i, .is_last_i, .no_byte_i,
    .wr_valid_o(wr_valid), .wr_data_o(wr_data), .wr_ready_i(wr_ready)
  );

  smd_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(wr_valid), .wr_data_i(wr_data), .wr_ready_o(wr_ready),
    .rd_valid_o(rd_valid), .rd_data_o(rd_data), .rd_ready_i(rd_ready)
  );

  smd_back u_back (
    .clk_i, .rst_ni,
    .rd_valid_i(rd_valid), .rd_data_i(rd_data), .rd_ready_o(rd_ready),
    .empty_o(empty), .pop_i(pop),
    .digest_word_o, .word_index_o, .last_word_o
  );
endmodule
`default_nettype wire
